### design/cipb_pkg.sv
// Shared types and constants for the cheapest-insertion polygon builder.
// Holds the item structs and the controller-to-datapath command and status groups.
// No dependencies.
package cipb_pkg;

  typedef struct packed {
    logic               action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] placed_at;
    logic [8:0] point_total;
    logic       was_reversed;
    logic       dropped;
  } out_item_t;

  // Actions carried by the item.
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Source of the data written into the point store.
  typedef enum logic [1:0] {
    WS_P  = 2'd0,
    WS_RD = 2'd1,
    WS_V0 = 2'd2
  } wsel_t;

  // Operand pair for the distance unit.
  typedef enum logic {
    DS_PB = 1'b0,
    DS_AB = 1'b1
  } dsel_t;

  // Last step of the shoelace product sequence (six products plus one drain step).
  localparam logic [2:0] AREA_LAST = 3'd6;

  typedef struct packed {
    logic       load_p;
    logic       rd_en;
    logic       wr_en;
    wsel_t      wr_sel;
    logic       cap_v0;
    logic       cap_v1;
    logic       cap_b;
    logic       b_from_v0;
    logic       area_en;
    logic [2:0] area_step;
    logic       dist_start;
    dsel_t      dist_sel;
    logic       take_dpb;
    logic       eval;
    logic       first;
    logic       advance;
  } dp_cmd_t;

  typedef struct packed {
    logic dist_done;
    logic area_pos;
    logic cost_less;
  } dp_stat_t;

endpackage

### design/cipb_dist.sv
// Distance unit: floor(sqrt(dx*dx + dy*dy)) for two points, computed over several cycles.
// One squaring multiplier, then a digit-by-digit square root producing one result bit per cycle.
// Depends on nothing.
module cipb_dist #(
  parameter int CB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [CB-1:0] ax,
  input  logic signed [CB-1:0] ay,
  input  logic signed [CB-1:0] bx,
  input  logic signed [CB-1:0] by,
  output logic                 done,
  output logic [CB:0]          len
);

  localparam int R_W   = CB + 1;
  localparam int SQ_W  = 2 * R_W;
  localparam int REM_W = R_W + 2;
  localparam int LAST  = R_W + 1;
  localparam int CW    = $clog2(LAST + 1);

  logic              run_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [CB-1:0]     adx_r, ady_r;
  logic [SQ_W-1:0]   sq_r;
  logic [R_W-1:0]    root_r;
  logic [REM_W-1:0]  rem_r;

  logic signed [CB:0] dx, dy, ndx, ndy;
  logic [CB-1:0]      mop;
  logic [2*CB-1:0]    msq;
  logic [REM_W-1:0]   rem_sh, trial;

  assign dx  = {bx[CB-1], bx} - {ax[CB-1], ax};
  assign dy  = {by[CB-1], by} - {ay[CB-1], ay};
  assign ndx = -dx;
  assign ndy = -dy;

  assign mop = (cnt_r == '0) ? adx_r : ady_r;
  assign msq = mop * mop;

  assign rem_sh = {rem_r[REM_W-3:0], sq_r[SQ_W-1:SQ_W-2]};
  assign trial  = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == CW'(LAST)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      adx_r <= dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
      ady_r <= dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];
    end else if (run_r) begin
      if (cnt_r == '0) begin
        sq_r <= SQ_W'(msq);
      end else if (cnt_r == CW'(1)) begin
        sq_r   <= sq_r + SQ_W'(msq);
        rem_r  <= '0;
        root_r <= '0;
      end else begin
        // One root bit per cycle: bring down two bits of the square and try the next digit.
        sq_r <= {sq_r[SQ_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[R_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[R_W-2:0], 1'b0};
        end
      end
    end
  end

  assign done = done_r;
  assign len  = root_r;

endmodule

### design/cipb_datapath.sv
// Datapath: point store, coordinate registers, shoelace accumulator and detour cost compare.
// Acts on commands from the controller; instantiates cipb_dist. Uses cipb_pkg.
module cipb_datapath #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 16,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cipb_pkg::dp_cmd_t  cmd,
  input  logic [AW-1:0]      addr,
  input  cipb_pkg::in_item_t in_item,
  output cipb_pkg::dp_stat_t stat
);

  localparam int CB     = COORD_BITS;
  localparam int R_W    = CB + 1;
  localparam int COST_W = R_W + 2;
  localparam int AREA_W = 2 * CB + 3;

  logic signed [CB-1:0] mem_x [MAX_POINTS];
  logic signed [CB-1:0] mem_y [MAX_POINTS];

  logic signed [CB-1:0] rdx_r, rdy_r;
  logic signed [CB-1:0] px_r, py_r, v0x_r, v0y_r, v1x_r, v1y_r;
  logic signed [CB-1:0] ax_r, ay_r, bx_r, by_r;
  logic [R_W-1:0]       dpa_r, dpb_r;
  logic signed [COST_W-1:0] min_cost_r;
  logic signed [2*CB-1:0]   prod_r;
  logic                     sub_r;
  logic signed [AREA_W-1:0] acc_r;

  logic signed [CB-1:0] wdx, wdy, ma, mb, dax, day;
  logic signed [CB-1:0] bnx, bny, dbx, dby;
  logic signed [2*CB-1:0] mul;
  logic [R_W-1:0]         len;
  logic                   dist_done;
  logic signed [COST_W-1:0] cost;
  logic                   less;

  always_comb begin
    case (cmd.wr_sel)
      cipb_pkg::WS_RD: begin wdx = rdx_r; wdy = rdy_r; end
      cipb_pkg::WS_V0: begin wdx = v0x_r; wdy = v0y_r; end
      default:         begin wdx = px_r;  wdy = py_r;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_x[addr] <= wdx;
      mem_y[addr] <= wdy;
    end
    if (cmd.rd_en) begin
      rdx_r <= mem_x[addr];
      rdy_r <= mem_y[addr];
    end
  end

  // Shoelace terms in order: +x0*y1, -x1*y0, +x1*y2, -x2*y1, +x2*y0, -x0*y2.
  always_comb begin
    case (cmd.area_step)
      3'd1:    begin ma = v1x_r; mb = v0y_r; end
      3'd2:    begin ma = v1x_r; mb = py_r;  end
      3'd3:    begin ma = px_r;  mb = v1y_r; end
      3'd4:    begin ma = px_r;  mb = v0y_r; end
      3'd5:    begin ma = v0x_r; mb = py_r;  end
      default: begin ma = v0x_r; mb = v1y_r; end
    endcase
  end

  assign mul = ma * mb;

  always_ff @(posedge clk) begin
    if (cmd.area_en) begin
      prod_r <= mul;
      sub_r  <= cmd.area_step[0];
      if (cmd.area_step == 3'd0) begin
        acc_r <= '0;
      end else if (sub_r) begin
        acc_r <= acc_r - AREA_W'(prod_r);
      end else begin
        acc_r <= acc_r + AREA_W'(prod_r);
      end
    end
  end

  // The new far end of the edge reaches the distance unit in the cycle it is captured.
  assign bnx = cmd.b_from_v0 ? v0x_r : rdx_r;
  assign bny = cmd.b_from_v0 ? v0y_r : rdy_r;
  assign dbx = cmd.cap_b ? bnx : bx_r;
  assign dby = cmd.cap_b ? bny : by_r;

  assign dax = (cmd.dist_sel == cipb_pkg::DS_AB) ? ax_r : px_r;
  assign day = (cmd.dist_sel == cipb_pkg::DS_AB) ? ay_r : py_r;

  cipb_dist #(.CB(CB)) u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.dist_start),
    .ax    (dax),
    .ay    (day),
    .bx    (dbx),
    .by    (dby),
    .done  (dist_done),
    .len   (len)
  );

  // Detour of edge (a, b) through p: |p-a| + |b-p| - |b-a|.
  assign cost = $signed({2'b00, dpa_r}) + $signed({2'b00, dpb_r}) - $signed({2'b00, len});
  assign less = cmd.first || (cost < min_cost_r);

  always_ff @(posedge clk) begin
    if (cmd.load_p) begin
      px_r <= CB'(in_item.pos_x);
      py_r <= CB'(in_item.pos_y);
    end
    if (cmd.cap_v0) begin
      v0x_r <= rdx_r;
      v0y_r <= rdy_r;
    end
    if (cmd.cap_v1) begin
      v1x_r <= rdx_r;
      v1y_r <= rdy_r;
    end
    if (cmd.cap_b) begin
      bx_r <= bnx;
      by_r <= bny;
    end
    if (cmd.take_dpb) begin
      dpb_r <= len;
    end
    if (cmd.advance) begin
      ax_r  <= bx_r;
      ay_r  <= by_r;
      dpa_r <= cmd.take_dpb ? len : dpb_r;
    end
    if (cmd.eval && less) begin
      min_cost_r <= cost;
    end
  end

  assign stat.dist_done = dist_done;
  assign stat.area_pos  = (acc_r > 0);
  assign stat.cost_less = less;

endmodule

### design/cipb_ctrl.sv
// Controller state machine: sequences append, winding check, edge scan, ring shift and placement.
// Drives the datapath by command struct and produces the result strobe. Uses cipb_pkg.
module cipb_ctrl #(
  parameter int MAX_POINTS = 256,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_action,
  output logic                busy,
  output cipb_pkg::dp_cmd_t   cmd,
  output logic [AW-1:0]       addr,
  input  cipb_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output cipb_pkg::out_item_t out_item
);

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_APPEND = 17'h00002,
    S_AR_RD0 = 17'h00004,
    S_AR_RD1 = 17'h00008,
    S_AR_RD2 = 17'h00010,
    S_AR_MUL = 17'h00020,
    S_AR_CHK = 17'h00040,
    S_REV0   = 17'h00080,
    S_REV1   = 17'h00100,
    S_SC_RD  = 17'h00200,
    S_SC_CAP = 17'h00400,
    S_SC_D1  = 17'h00800,
    S_SC_D2  = 17'h01000,
    S_SC_ADV = 17'h02000,
    S_SH_RD  = 17'h04000,
    S_SH_WR  = 17'h08000,
    S_PLACE  = 17'h10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     best_r, best_nxt;
  logic [CNT_W-1:0]     at_r, at_nxt;
  logic                 out_valid_r, out_valid_nxt;
  cipb_pkg::out_item_t  out_r, out_nxt;

  logic [CNT_W-1:0] idx_m1, at_c;

  function automatic cipb_pkg::out_item_t mk_out(input logic [CNT_W-1:0] placed,
                                                 input logic [CNT_W-1:0] total,
                                                 input logic rev, input logic drop);
    cipb_pkg::out_item_t o;
    o.placed_at    = 8'(placed);
    o.point_total  = 9'(total);
    o.was_reversed = rev;
    o.dropped      = drop;
    return o;
  endfunction

  assign idx_m1 = idx_r - 1'b1;
  assign at_c   = (stat.cost_less ? idx_m1 : best_r) + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    at_nxt        = at_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cmd           = '0;
    addr          = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_p = 1'b1;
          if (in_action == cipb_pkg::ACT_CLEAR) begin
            count_nxt     = '0;
            out_valid_nxt = 1'b1;
            out_nxt       = mk_out('0, '0, 1'b0, 1'b0);
          end else if (count_r == CNT_W'(MAX_POINTS)) begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_out('0, count_r, 1'b0, 1'b1);
          end else if (count_r < CNT_W'(3)) begin
            state_nxt = S_APPEND;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_SC_RD;
          end
        end
      end
      S_APPEND: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = cipb_pkg::WS_P;
        addr       = count_r[AW-1:0];
        count_nxt  = count_r + 1'b1;
        if (count_r == CNT_W'(2)) begin
          state_nxt = S_AR_RD0;
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out(count_r, count_nxt, 1'b0, 1'b0);
          state_nxt     = S_IDLE;
        end
      end
      S_AR_RD0: begin
        cmd.rd_en = 1'b1;
        addr      = '0;
        state_nxt = S_AR_RD1;
      end
      S_AR_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.cap_v0 = 1'b1;
        addr       = AW'(1);
        state_nxt  = S_AR_RD2;
      end
      S_AR_RD2: begin
        cmd.cap_v1 = 1'b1;
        idx_nxt    = '0;
        state_nxt  = S_AR_MUL;
      end
      S_AR_MUL: begin
        cmd.area_en   = 1'b1;
        cmd.area_step = idx_r[2:0];
        if (idx_r[2:0] == cipb_pkg::AREA_LAST) begin
          state_nxt = S_AR_CHK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_AR_CHK: begin
        if (stat.area_pos) begin
          state_nxt = S_REV0;
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out(CNT_W'(2), count_r, 1'b0, 1'b0);
          state_nxt     = S_IDLE;
        end
      end
      // Reversing three points swaps the first and the last.
      S_REV0: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = cipb_pkg::WS_P;
        addr       = '0;
        state_nxt  = S_REV1;
      end
      S_REV1: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = cipb_pkg::WS_V0;
        addr          = AW'(2);
        out_valid_nxt = 1'b1;
        out_nxt       = mk_out('0, count_r, 1'b1, 1'b0);
        state_nxt     = S_IDLE;
      end
      S_SC_RD: begin
        cmd.rd_en = 1'b1;
        addr      = idx_r[AW-1:0];
        state_nxt = S_SC_CAP;
      end
      S_SC_CAP: begin
        cmd.cap_b      = 1'b1;
        cmd.b_from_v0  = (idx_r == count_r);
        cmd.cap_v0     = (idx_r == '0);
        cmd.dist_start = 1'b1;
        cmd.dist_sel   = cipb_pkg::DS_PB;
        state_nxt      = S_SC_D1;
      end
      S_SC_D1: begin
        if (stat.dist_done) begin
          cmd.take_dpb = 1'b1;
          if (idx_r == '0) begin
            state_nxt = S_SC_ADV;
          end else begin
            cmd.dist_start = 1'b1;
            cmd.dist_sel   = cipb_pkg::DS_AB;
            state_nxt      = S_SC_D2;
          end
        end
      end
      S_SC_D2: begin
        if (stat.dist_done) begin
          cmd.eval    = 1'b1;
          cmd.first   = (idx_r == CNT_W'(1));
          cmd.advance = 1'b1;
          if (stat.cost_less) begin
            best_nxt = idx_m1;
          end
          if (idx_r == count_r) begin
            at_nxt    = at_c;
            idx_nxt   = count_r;
            state_nxt = (at_c == count_r) ? S_PLACE : S_SH_RD;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_SC_RD;
          end
        end
      end
      S_SC_ADV: begin
        cmd.advance = 1'b1;
        idx_nxt     = CNT_W'(1);
        state_nxt   = S_SC_RD;
      end
      S_SH_RD: begin
        cmd.rd_en = 1'b1;
        addr      = idx_m1[AW-1:0];
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = cipb_pkg::WS_RD;
        addr       = idx_r[AW-1:0];
        idx_nxt    = idx_m1;
        state_nxt  = (idx_m1 == at_r) ? S_PLACE : S_SH_RD;
      end
      S_PLACE: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = cipb_pkg::WS_P;
        addr          = at_r[AW-1:0];
        count_nxt     = count_r + 1'b1;
        out_valid_nxt = 1'b1;
        out_nxt       = mk_out(at_r, count_nxt, 1'b0, 1'b0);
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    best_r <= best_nxt;
    at_r   <= at_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("ring count above store size");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while still working");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (out_valid_r || state_r != S_IDLE))
    else $error("accepted item neither finished nor started");

  a_shift_above: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SH_RD) |-> (idx_r > at_r))
    else $error("ring shift passed the insertion point");

endmodule

### design/cheapest_insertion_polygon_builder_core.sv
// Top level of the cheapest-insertion polygon builder.
// Joins cipb_ctrl and cipb_datapath (with cipb_dist). Uses cipb_pkg.
//
// Usage: drive in_item and raise start; the item is taken at a clock edge where
// start is high and busy is low. Each item yields exactly one result, shown on
// out_item for one cycle with out_valid high; the receiver cannot stall, so it
// must take the result in that cycle. busy falls in the same cycle the result shows.
// Clear and drop are answered from the idle state; the first two points are appended
// with one store write; the third point adds a winding check and a swap of its ends
// if the ring is reversed. From the fourth point on, an item scans every edge of a
// ring of n points on the single distance unit, whose square root yields one bit per
// cycle, then moves each stored point above the insertion slot up by one on the
// single store port. Items are handled one at a time.
// Reset empties the ring; store contents are undefined until written.
module cheapest_insertion_polygon_builder_core #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cipb_pkg::in_item_t  in_item,
  output logic                out_valid,
  output cipb_pkg::out_item_t out_item
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  cipb_pkg::dp_cmd_t  cmd;
  cipb_pkg::dp_stat_t stat;
  logic [AW-1:0]      addr;

  cipb_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_item.action),
    .busy      (busy),
    .cmd       (cmd),
    .addr      (addr),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  cipb_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .addr    (addr),
    .in_item (in_item),
    .stat    (stat)
  );

endmodule

### dv/tb_cheapest_insertion_polygon_builder_core.sv
// Testbench for cheapest_insertion_polygon_builder_core: directed table, then random rings.
// Each result is checked against its typed table value or an in-bench ring predictor. Depends on cipb_pkg and the core.
`timescale 1ns / 1ps

module tb_cheapest_insertion_polygon_builder_core;

  localparam int RING_DEPTH  = 256;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int IN_W        = $bits(cipb_pkg::in_item_t);

  typedef struct {
    cipb_pkg::in_item_t  item;
    bit                  typed;
    cipb_pkg::out_item_t result;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  cipb_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  cipb_pkg::out_item_t out_item;

  cheapest_insertion_polygon_builder_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted ring and the queue of results still owed by the block.
  logic signed [15:0]  ring_px [RING_DEPTH];
  logic signed [15:0]  ring_py [RING_DEPTH];
  int                  ring_len = 0;
  cipb_pkg::out_item_t owed_results[$];
  int                  mismatches = 0;
  longint              cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint span(longint ax, longint ay, longint bx, longint by);
    longint dx = bx - ax;
    longint dy = by - ay;
    return longint'(int_sqrt(longint'(dx * dx + dy * dy)));
  endfunction

  function automatic cipb_pkg::out_item_t place_point(cipb_pkg::in_item_t it);
    cipb_pkg::out_item_t r = '0;
    longint    area = 0;
    longint    cost, low_cost;
    int        best, j;
    logic signed [15:0] tx;
    if (it.action == cipb_pkg::ACT_CLEAR) begin
      ring_len = 0;
    end else if (ring_len >= RING_DEPTH) begin
      r.dropped = 1'b1;
    end else if (ring_len < 3) begin
      ring_px[ring_len] = it.pos_x;
      ring_py[ring_len] = it.pos_y;
      r.placed_at = ring_len[7:0];
      ring_len++;
      if (ring_len == 3) begin
        for (int i = 0; i < 3; i++) begin
          j = (i == 2) ? 0 : i + 1;
          area += longint'(ring_px[i]) * ring_py[j] - longint'(ring_px[j]) * ring_py[i];
        end
        // Counter-clockwise triangle: swap the ends so it winds clockwise.
        if (area > 0) begin
          tx = ring_px[0]; ring_px[0] = ring_px[2]; ring_px[2] = tx;
          tx = ring_py[0]; ring_py[0] = ring_py[2]; ring_py[2] = tx;
          r.was_reversed = 1'b1;
          r.placed_at = '0;
        end
      end
    end else begin
      best = 0;
      low_cost = 0;
      for (int i = 0; i < ring_len; i++) begin
        j = (i + 1 == ring_len) ? 0 : i + 1;
        cost = span(ring_px[i], ring_py[i], it.pos_x, it.pos_y)
             + span(it.pos_x, it.pos_y, ring_px[j], ring_py[j])
             - span(ring_px[i], ring_py[i], ring_px[j], ring_py[j]);
        if (i == 0 || cost < low_cost) begin
          low_cost = cost;
          best = i;
        end
      end
      for (int i = ring_len; i > best + 1; i--) begin
        ring_px[i] = ring_px[i-1];
        ring_py[i] = ring_py[i-1];
      end
      ring_px[best+1] = it.pos_x;
      ring_py[best+1] = it.pos_y;
      ring_len++;
      r.placed_at = 8'(best + 1);
    end
    r.point_total = 9'(ring_len);
    return r;
  endfunction

  // Holds start high until the block takes the item; start is left high for a
  // following item and only lowered by take_break.
  task automatic send_item(cipb_pkg::in_item_t it, bit typed,
                           cipb_pkg::out_item_t typed_result);
    cipb_pkg::out_item_t predicted;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = place_point(it);
    owed_results = {owed_results, typed ? typed_result : predicted};
  endtask

  task automatic take_break(int n);
    if (n > 0) begin
      start   <= 1'b0;
      in_item <= IN_W'({$urandom, $urandom});
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic cipb_pkg::in_item_t point(int x, int y);
    cipb_pkg::in_item_t it;
    it.action = cipb_pkg::ACT_ADD;
    it.pos_x  = 16'(x);
    it.pos_y  = 16'(y);
    return it;
  endfunction

  function automatic cipb_pkg::in_item_t clear_item();
    cipb_pkg::in_item_t it = IN_W'({$urandom, $urandom});
    it.action = cipb_pkg::ACT_CLEAR;
    return it;
  endfunction

  function automatic cipb_pkg::out_item_t res(int at, int total, bit rev);
    cipb_pkg::out_item_t r;
    r.placed_at    = 8'(at);
    r.point_total  = 9'(total);
    r.was_reversed = rev;
    r.dropped      = 1'b0;
    return r;
  endfunction

  function automatic cipb_pkg::in_item_t random_point(bit near);
    if (near) return point($urandom_range(0, 96) - 48, $urandom_range(0, 96) - 48);
    return point($urandom, $urandom);
  endfunction

  always @(posedge clk) begin
    cipb_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        want = owed_results.pop_front();
        if (out_item !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  stim_row_t directed[$];
  int        sent;
  int        burst;
  int        goal;
  bit        near;

  initial begin
    directed = '{
      '{clear_item(), 1, res(0, 0, 0)},
      '{point(-32768, -32768), 1, res(0, 1, 0)},
      '{point(32767, -32768), 1, res(1, 2, 0)},
      // Counter-clockwise third point gets reversed to index 0.
      '{point(32767, 32767), 1, res(0, 3, 1)},
      '{point(-32768, 32767), 0, '0},
      '{point(0, 0), 0, '0},
      '{point(1, -1), 0, '0},
      '{point(-1, 1), 0, '0},
      '{clear_item(), 1, res(0, 0, 0)},
      // A collinear triangle keeps its order.
      '{point(0, 0), 1, res(0, 1, 0)},
      '{point(16, 16), 1, res(1, 2, 0)},
      '{point(32, 32), 1, res(2, 3, 0)},
      '{point(48, 48), 0, '0},
      '{point(16, 16), 0, '0},
      '{clear_item(), 1, res(0, 0, 0)},
      // A clockwise triangle is left alone.
      '{point(0, 0), 1, res(0, 1, 0)},
      '{point(0, 16), 1, res(1, 2, 0)},
      '{point(16, 0), 1, res(2, 3, 0)},
      '{point(8, 8), 0, '0},
      '{point(-21846, 21845), 0, '0},
      '{clear_item(), 1, res(0, 0, 0)}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      send_item(directed[k].item, directed[k].typed, directed[k].result);
      if ($urandom_range(0, 3) == 0) take_break($urandom_range(1, 5));
    end

    sent  = 0;
    burst = $urandom_range(1, 8);
    while (sent < 780) begin
      if (sent > 300 && sent < 320) begin
        // Let the block drain, then fill the store to the top and overflow it.
        take_break(1);
        while (owed_results.size() != 0) @(posedge clk);
        send_item(clear_item(), 0, '0);
        for (int i = 0; i < RING_DEPTH + 4; i++) begin
          send_item(random_point($urandom_range(0, 1)), 0, '0);
          if ($urandom_range(0, 15) == 0) take_break($urandom_range(1, 4));
        end
        send_item(clear_item(), 0, '0);
        sent += RING_DEPTH + 6;
      end
      goal = $urandom_range(2, 12);
      near = $urandom_range(0, 1);
      for (int i = 0; i < goal; i++) begin
        if ($urandom_range(0, 29) == 0) send_item(clear_item(), 0, '0);
        else send_item(random_point(near), 0, '0);
        sent++;
        if (--burst == 0) begin
          take_break($urandom_range(1, 20));
          burst = $urandom_range(1, 10);
        end
      end
      send_item(clear_item(), 0, '0);
      sent++;
    end
    take_break(1);

    while (owed_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
design/cipb_pkg.sv
design/cipb_dist.sv
design/cipb_datapath.sv
design/cipb_ctrl.sv
design/cheapest_insertion_polygon_builder_core.sv
dv/tb_cheapest_insertion_polygon_builder_core.sv
